// ===== design/nlp_pkg.sv =====
// Shared types, codes and helper functions of the numeric literal parser.
// Used by the front classifier, the character queue, the parse back end and the top level.
package nlp_pkg;

    localparam int DEF_WORD_BITS   = 64;
    localparam int DEF_QUEUE_DEPTH = 4;
    localparam int CNT_BITS        = 7;
    localparam int WIDTH_BITS      = 7;

    localparam logic [CNT_BITS-1:0] CNT_MAX = 7'd127;

    localparam logic [2:0] PH_LEAD = 3'd0;
    localparam logic [2:0] PH_ZERO = 3'd1;
    localparam logic [2:0] PH_BIN  = 3'd2;
    localparam logic [2:0] PH_HEX  = 3'd3;
    localparam logic [2:0] PH_DEC  = 3'd4;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_BIN = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_EMPTY     = 4'd1;
    localparam logic [3:0] ERR_BIN_NODIG = 4'd2;
    localparam logic [3:0] ERR_BIN_LONG  = 4'd3;
    localparam logic [3:0] ERR_BIN_BAD   = 4'd4;
    localparam logic [3:0] ERR_HEX_NODIG = 4'd5;
    localparam logic [3:0] ERR_HEX_BAD   = 4'd6;
    localparam logic [3:0] ERR_DEC_BAD   = 4'd7;
    localparam logic [3:0] ERR_OVERFLOW  = 4'd8;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd64;

    typedef struct packed {
        logic       last;
        logic       ws;
        logic       zero_ch;
        logic       b_ch;
        logic       x_ch;
        logic       bin_ok;
        logic       hex_ok;
        logic       dec_ok;
        logic [3:0] digit;
    } nlp_char_t;

    function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] a,
                                                    input logic [CNT_BITS-1:0] b);
        logic [CNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_BITS-1:0];
    endfunction

    function automatic logic [3:0] bad_code(input logic [1:0] radix);
        logic [3:0] code;
        case (radix)
            RADIX_BIN: code = ERR_BIN_BAD;
            RADIX_HEX: code = ERR_HEX_BAD;
            default:   code = ERR_DEC_BAD;
        endcase
        return code;
    endfunction

endpackage

// ===== design/nlp_front.sv =====
// Front end of the numeric literal parser: accepts input transactions and classifies
// each character into a compact record for the queue. Depends on nlp_pkg.
module nlp_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 push,
    output nlp_pkg::nlp_char_t   push_data
);
    import nlp_pkg::*;

    logic [7:0] c;
    logic       is_dec;
    logic       is_lo_hex;
    logic       is_up_hex;

    assign c         = s_tdata;
    assign is_dec    = (c >= 8'h30) && (c <= 8'h39);
    assign is_lo_hex = (c >= 8'h61) && (c <= 8'h66);
    assign is_up_hex = (c >= 8'h41) && (c <= 8'h46);

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb begin
        push_data.last    = s_tlast;
        push_data.ws      = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
        push_data.zero_ch = (c == 8'h30);
        push_data.b_ch    = (c == 8'h62) || (c == 8'h42);
        push_data.x_ch    = (c == 8'h78) || (c == 8'h58);
        push_data.bin_ok  = (c == 8'h30) || (c == 8'h31);
        push_data.dec_ok  = is_dec;
        push_data.hex_ok  = is_dec || is_lo_hex || is_up_hex;
        if (is_dec) begin
            push_data.digit = c[3:0];
        end else if (is_lo_hex || is_up_hex) begin
            push_data.digit = c[3:0] + 4'd9;
        end else begin
            push_data.digit = 4'd0;
        end
    end

endmodule

// ===== design/nlp_queue.sv =====
// Short queue of classified characters between the front end and the parse back end.
// Depends on nlp_pkg for the record type.
module nlp_queue #(
    parameter int DEPTH = nlp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  nlp_pkg::nlp_char_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               q_valid,
    output nlp_pkg::nlp_char_t q_data
);
    import nlp_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    nlp_char_t           entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/nlp_back.sv =====
// Parse back end: walks the literal state machine one character per cycle while any are queued (a last one
// waits for a free output), accumulates the value, tracks errors and holds the finished result. Depends on nlp_pkg.
module nlp_back #(
    parameter int WORD_BITS = nlp_pkg::DEF_WORD_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  nlp_pkg::nlp_char_t q_data,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [63:0]        out_value,
    output logic [3:0]         out_error,
    output logic [1:0]         out_radix
);
    import nlp_pkg::*;

    logic [2:0]           phase_reg, phase_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [1:0]           radix_reg, radix_next;
    logic [3:0]           ferr_reg, ferr_next;
    logic                 ovf_reg, ovf_next;
    logic [CNT_BITS-1:0]  wsp_reg, wsp_next;

    logic                 out_valid_reg, out_valid_next;
    logic [63:0]          out_value_reg;
    logic [3:0]           out_error_reg;
    logic [1:0]           out_radix_reg;

    logic                 do_body;
    logic [WORD_BITS+3:0] dec_prod;
    logic [3:0]           fin_err;
    logic                 take_result;
    nlp_char_t            c;

    assign c           = q_data;
    assign pop         = q_valid && (!c.last || !out_valid_reg || out_ready);
    assign take_result = pop && c.last;

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        radix_next = radix_reg;
        ferr_next  = ferr_reg;
        ovf_next   = ovf_reg;
        wsp_next   = wsp_reg;
        do_body    = 1'b0;
        dec_prod   = '0;
        fin_err    = ERR_NONE;
        if (pop) begin
            case (phase_reg)
                PH_LEAD: begin
                    if (!c.ws) begin
                        if (c.zero_ch) begin
                            phase_next = PH_ZERO;
                        end else begin
                            phase_next = PH_DEC;
                            radix_next = RADIX_DEC;
                            do_body    = 1'b1;
                        end
                    end
                end
                PH_ZERO: begin
                    if (c.b_ch) begin
                        phase_next = PH_BIN;
                        radix_next = RADIX_BIN;
                    end else if (c.x_ch) begin
                        phase_next = PH_HEX;
                        radix_next = RADIX_HEX;
                    end else begin
                        phase_next = PH_DEC;
                        radix_next = RADIX_DEC;
                        acc_next   = '0;
                        cnt_next   = 7'd1;
                        do_body    = 1'b1;
                    end
                end
                default: begin
                    do_body = 1'b1;
                end
            endcase

            if (do_body) begin
                if (c.ws) begin
                    wsp_next = sat_add(wsp_next, 7'd1);
                end else begin
                    if (wsp_next != '0) begin
                        if (ferr_next == ERR_NONE) begin
                            ferr_next = bad_code(radix_next);
                        end
                        cnt_next = sat_add(cnt_next, wsp_next);
                        wsp_next = '0;
                    end
                    cnt_next = sat_add(cnt_next, 7'd1);
                    dec_prod = ({4'b0, acc_next} << 3) + ({4'b0, acc_next} << 1)
                             + (WORD_BITS + 4)'(c.digit);
                    case (radix_next)
                        RADIX_BIN: begin
                            if (c.bin_ok) begin
                                acc_next = {acc_next[WORD_BITS-2:0], c.digit[0]};
                            end else if (ferr_next == ERR_NONE) begin
                                ferr_next = bad_code(radix_next);
                            end
                        end
                        RADIX_HEX: begin
                            if (!c.hex_ok) begin
                                if (ferr_next == ERR_NONE) begin
                                    ferr_next = bad_code(radix_next);
                                end
                            end else if (!ovf_next) begin
                                if (acc_next[WORD_BITS-1 -: 4] != 4'd0) begin
                                    ovf_next = 1'b1;
                                end else begin
                                    acc_next = {acc_next[WORD_BITS-5:0], c.digit};
                                end
                            end
                        end
                        default: begin
                            if (!c.dec_ok) begin
                                if (ferr_next == ERR_NONE) begin
                                    ferr_next = bad_code(radix_next);
                                end
                            end else if (!ovf_next) begin
                                if (dec_prod[WORD_BITS+3 -: 4] != 4'd0) begin
                                    ovf_next = 1'b1;
                                end else begin
                                    acc_next = dec_prod[WORD_BITS-1:0];
                                end
                            end
                        end
                    endcase
                end
            end

            case (phase_next)
                PH_LEAD: fin_err = ERR_EMPTY;
                PH_ZERO: fin_err = ERR_NONE;
                PH_BIN: begin
                    if (cnt_next == '0) begin
                        fin_err = ERR_BIN_NODIG;
                    end else if (cnt_next > CNT_BITS'(WORD_BITS)) begin
                        fin_err = ERR_BIN_LONG;
                    end else begin
                        fin_err = ferr_next;
                    end
                end
                PH_HEX: begin
                    if (cnt_next == '0) begin
                        fin_err = ERR_HEX_NODIG;
                    end else if (ferr_next != ERR_NONE) begin
                        fin_err = ferr_next;
                    end else begin
                        fin_err = ovf_next ? ERR_OVERFLOW : ERR_NONE;
                    end
                end
                default: begin
                    if (ferr_next != ERR_NONE) begin
                        fin_err = ferr_next;
                    end else begin
                        fin_err = ovf_next ? ERR_OVERFLOW : ERR_NONE;
                    end
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (take_result) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || take_result) begin
            phase_reg <= PH_LEAD;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            radix_reg <= RADIX_DEC;
            ferr_reg  <= ERR_NONE;
            ovf_reg   <= 1'b0;
            wsp_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            radix_reg <= radix_next;
            ferr_reg  <= ferr_next;
            ovf_reg   <= ovf_next;
            wsp_reg   <= wsp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_result) begin
            out_value_reg <= (fin_err == ERR_NONE) ? 64'(acc_next) : 64'd0;
            out_error_reg <= fin_err;
            out_radix_reg <= radix_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_error = out_error_reg;
    assign out_radix = out_radix_reg;

endmodule

// ===== design/numeric_literal_parser.sv =====
// Numeric literal parser: one character per transaction in, one result per literal out.
// A result is offered once the last character has passed the queue and the back end's output register.
// Throughput: one character per cycle, unless an unread result holds back a literal's last character.
// Reset (aresetn low, synchronous): parser state, queue and output valid are cleared and the
// result width returns to 64 bits. Depends on nlp_pkg, nlp_front, nlp_queue and nlp_back.
module numeric_literal_parser #(
    parameter int WORD_BITS   = nlp_pkg::DEF_WORD_BITS,
    parameter int QUEUE_DEPTH = nlp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // value [63:0], error_code [67:64], zero fill
    output logic [2:0]  m_tuser,  // truncated [0], radix_kind [2:1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nlp_pkg::*;

    logic                  q_full;
    logic                  push;
    nlp_char_t             push_data;
    logic                  pop;
    logic                  q_valid;
    nlp_char_t             q_data;
    logic [63:0]           raw_value;
    logic [3:0]            raw_error;
    logic [1:0]            raw_radix;
    logic [63:0]           clipped;
    logic [WIDTH_BITS-1:0] width_reg;
    logic [63:0]           mask_reg, mask_next;
    logic                  cfg_write;

    nlp_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    nlp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    nlp_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (raw_value),
        .out_error (raw_error),
        .out_radix (raw_radix)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {25'd0, width_reg} : 32'd0;

    always_comb begin
        if (pwdata[6:0] == 7'd0) begin
            mask_next = 64'd0;
        end else if (pwdata[6:0] >= 7'd64) begin
            mask_next = '1;
        end else begin
            mask_next = (64'd1 << pwdata[5:0]) - 64'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
            mask_reg  <= '1;
        end else if (cfg_write) begin
            width_reg <= pwdata[6:0];
            mask_reg  <= mask_next;
        end
    end

    assign clipped = raw_value & mask_reg;
    assign m_tdata = {4'd0, raw_error, clipped};
    assign m_tuser = {raw_radix, (clipped != raw_value)};

endmodule
